// ===== hw/rtl/line_vote_accumulator_core_defines.svh =====
// Assertion macros for the RTL file that checks itself.
// Each macro expects clk and rst_n in scope.
`ifndef LINE_VOTE_ACCUMULATOR_CORE_DEFINES_SVH
`define LINE_VOTE_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LVA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lva_pkg.sv =====
package lva_pkg;

    // Store geometry and count width
    localparam int MAX_ROWS   = 512;
    localparam int MAX_COLS   = 512;
    localparam int COUNT_BITS = 16;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS  = $clog2(DEPTH);

    // Field widths
    localparam int COORD_BITS   = 12;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS     = COORD_BITS + 3;
    localparam int READ_BITS    = 9;
    localparam int DIM_BITS     = 10;
    localparam int VOTE_BITS    = 16;
    localparam int VOTED_BITS   = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = DIM_BITS;

    // Register indexes and reset values
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b1;
    localparam logic [DIM_BITS-1:0]     DIM_RESET        = 10'd512;

    // Operation codes
    localparam logic OP_VOTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    typedef struct packed {
        logic                   operation;
        coord_t                 start_row;
        coord_t                 start_col;
        coord_t                 end_row;
        coord_t                 end_col;
        logic [READ_BITS-1:0]   read_row;
        logic [READ_BITS-1:0]   read_col;
    } req_t;

    typedef struct packed {
        logic [VOTE_BITS-1:0]   vote_count;
        logic [VOTED_BITS-1:0]  cells_voted;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic setup;
        logic walk;
        logic rd_issue;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic op_read;
        logic zero_len;
        logic walk_last;
        logic out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/lva_req_if.sv =====
interface lva_req_if;
    logic          valid;
    logic          ready;
    lva_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lva_rsp_if.sv =====
interface lva_rsp_if;
    logic          valid;
    logic          ready;
    lva_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lva_ctrl.sv =====
module lva_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lva_pkg::sts_t sts,
    output lva_pkg::cmd_t cmd
);

    lva_pkg::state_t state_reg;
    lva_pkg::state_t state_next;

    // State register; reset starts the store clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lva_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            lva_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = lva_pkg::ST_IDLE;
                end
            end
            lva_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lva_pkg::ST_SETUP;
                end
            end
            lva_pkg::ST_SETUP:
            begin
                if (sts.op_read)
                begin
                    state_next = lva_pkg::ST_READ;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = sts.zero_len ? lva_pkg::ST_DONE : lva_pkg::ST_WALK;
                end
            end
            lva_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = lva_pkg::ST_DRAIN;
                end
            end
            // last pending write back lands here
            lva_pkg::ST_DRAIN:
            begin
                state_next = lva_pkg::ST_DONE;
            end
            lva_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = lva_pkg::ST_DONE;
            end
            lva_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lva_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lva_datapath.sv =====
module lva_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lva_pkg::cmd_t                        cmd,
    output lva_pkg::sts_t                        sts,
    input  lva_pkg::req_t                        req_payload,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output lva_pkg::rsp_t                        rsp_payload,
    input  logic                                 cfg_we,
    input  logic [lva_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lva_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam lva_pkg::count_t COUNT_MAX = '1;
    localparam lva_pkg::addr_t  CLR_LAST  = lva_pkg::ADDR_BITS'(lva_pkg::DEPTH - 1);

    // Vote store
    lva_pkg::count_t vote_mem [lva_pkg::DEPTH];

    // Configuration registers
    logic [lva_pkg::DIM_BITS-1:0] height_reg;
    logic [lva_pkg::DIM_BITS-1:0] width_reg;

    // Captured transaction
    lva_pkg::req_t item_reg;

    // Stepper state
    logic                            col_major_reg;
    lva_pkg::coord_t                 m_reg;
    lva_pkg::coord_t                 k_reg;
    logic                            k_up_reg;
    logic                            k_move_reg;
    logic [lva_pkg::COORD_BITS-1:0]  dmaj_reg;
    logic [lva_pkg::COORD_BITS-1:0]  dmin_reg;
    lva_pkg::err_t                   e_reg;
    logic [lva_pkg::COORD_BITS-1:0]  cnt_reg;
    logic [lva_pkg::VOTED_BITS-1:0]  voted_reg;

    // Read-modify-write pipeline
    logic                            pend_valid_reg;
    lva_pkg::addr_t                  pend_addr_reg;
    lva_pkg::count_t                 rd_data_reg;
    logic                            rd_oob_reg;

    // Clearing pass and output register
    lva_pkg::addr_t                  clr_addr_reg;
    logic                            out_valid_reg;
    lva_pkg::rsp_t                   out_payload_reg;

    // Setup terms
    logic signed [lva_pkg::DIFF_BITS-1:0] dr_diff;
    logic signed [lva_pkg::DIFF_BITS-1:0] dc_diff;
    logic [lva_pkg::COORD_BITS-1:0]       dr_abs;
    logic [lva_pkg::COORD_BITS-1:0]       dc_abs;
    logic                                 col_major;
    lva_pkg::coord_t                      maj_a;
    lva_pkg::coord_t                      maj_b;
    lva_pkg::coord_t                      min_a;
    lva_pkg::coord_t                      min_b;
    logic                                 swap;
    lva_pkg::coord_t                      m_start;
    lva_pkg::coord_t                      k_start;
    lva_pkg::coord_t                      k_end;
    logic [lva_pkg::COORD_BITS-1:0]       dmaj;
    logic [lva_pkg::COORD_BITS-1:0]       dmin;

    // Walk terms
    lva_pkg::coord_t                      cur_row;
    lva_pkg::coord_t                      cur_col;
    logic                                 row_in;
    logic                                 col_in;
    logic                                 issue;
    logic                                 e_nonneg;
    lva_pkg::addr_t                       cell_addr;
    lva_pkg::addr_t                       read_addr;
    logic                                 read_oob;

    // Memory port selection
    logic                                 mem_we;
    lva_pkg::addr_t                       mem_waddr;
    lva_pkg::count_t                      mem_wdata;
    logic                                 mem_re;
    lva_pkg::addr_t                       mem_raddr;

    // Segment setup: deltas, major axis, walk direction
    always_comb
    begin
        dr_diff   = {item_reg.end_row[lva_pkg::COORD_BITS-1], item_reg.end_row}
                  - {item_reg.start_row[lva_pkg::COORD_BITS-1], item_reg.start_row};
        dc_diff   = {item_reg.end_col[lva_pkg::COORD_BITS-1], item_reg.end_col}
                  - {item_reg.start_col[lva_pkg::COORD_BITS-1], item_reg.start_col};
        dr_abs    = dr_diff[lva_pkg::DIFF_BITS-1] ? lva_pkg::COORD_BITS'(-dr_diff)
                                                  : dr_diff[lva_pkg::COORD_BITS-1:0];
        dc_abs    = dc_diff[lva_pkg::DIFF_BITS-1] ? lva_pkg::COORD_BITS'(-dc_diff)
                                                  : dc_diff[lva_pkg::COORD_BITS-1:0];
        col_major = (dr_abs <= dc_abs);
        maj_a     = col_major ? item_reg.start_col : item_reg.start_row;
        maj_b     = col_major ? item_reg.end_col   : item_reg.end_row;
        min_a     = col_major ? item_reg.start_row : item_reg.start_col;
        min_b     = col_major ? item_reg.end_row   : item_reg.end_col;
        swap      = (maj_b < maj_a);
        m_start   = swap ? maj_b : maj_a;
        k_start   = swap ? min_b : min_a;
        k_end     = swap ? min_a : min_b;
        dmaj      = col_major ? dc_abs : dr_abs;
        dmin      = col_major ? dr_abs : dc_abs;
    end

    // Current cell and image bounds
    always_comb
    begin
        cur_row   = col_major_reg ? k_reg : m_reg;
        cur_col   = col_major_reg ? m_reg : k_reg;
        row_in    = !cur_row[lva_pkg::COORD_BITS-1]
                  && (lva_pkg::DIFF_BITS'($unsigned(cur_row)) < lva_pkg::DIFF_BITS'(height_reg))
                  && (lva_pkg::DIFF_BITS'($unsigned(cur_row)) < lva_pkg::DIFF_BITS'(lva_pkg::MAX_ROWS));
        col_in    = !cur_col[lva_pkg::COORD_BITS-1]
                  && (lva_pkg::DIFF_BITS'($unsigned(cur_col)) < lva_pkg::DIFF_BITS'(width_reg))
                  && (lva_pkg::DIFF_BITS'($unsigned(cur_col)) < lva_pkg::DIFF_BITS'(lva_pkg::MAX_COLS));
        issue     = cmd.walk && row_in && col_in;
        e_nonneg  = !e_reg[lva_pkg::ERR_BITS-1];
        cell_addr = lva_pkg::ADDR_BITS'($unsigned(cur_row))
                  * lva_pkg::ADDR_BITS'(lva_pkg::MAX_COLS)
                  + lva_pkg::ADDR_BITS'($unsigned(cur_col));
        read_addr = lva_pkg::ADDR_BITS'(item_reg.read_row)
                  * lva_pkg::ADDR_BITS'(lva_pkg::MAX_COLS)
                  + lva_pkg::ADDR_BITS'(item_reg.read_col);
        read_oob  = (lva_pkg::DIFF_BITS'(item_reg.read_row) >= lva_pkg::DIFF_BITS'(lva_pkg::MAX_ROWS))
                  || (lva_pkg::DIFF_BITS'(item_reg.read_col) >= lva_pkg::DIFF_BITS'(lva_pkg::MAX_COLS));
    end

    // Memory ports: clear sweep or saturating write back; one read
    always_comb
    begin
        mem_we    = cmd.clear || pend_valid_reg;
        mem_waddr = cmd.clear ? clr_addr_reg : pend_addr_reg;
        mem_wdata = cmd.clear ? '0
                  : ((rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1);
        mem_re    = issue || cmd.rd_issue;
        mem_raddr = cmd.rd_issue ? read_addr : cell_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vote_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= vote_mem[mem_raddr];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= lva_pkg::DIM_RESET;
            width_reg  <= lva_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lva_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                lva_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control registers: pending write, clear address, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= issue;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_payload;
        end
        if (issue)
        begin
            pend_addr_reg <= cell_addr;
        end
        if (cmd.rd_issue)
        begin
            rd_oob_reg <= read_oob;
        end
        if (cmd.setup)
        begin
            col_major_reg <= col_major;
            m_reg         <= m_start;
            k_reg         <= k_start;
            k_up_reg      <= (k_end > k_start);
            k_move_reg    <= (k_end != k_start);
            dmaj_reg      <= dmaj;
            dmin_reg      <= dmin;
            e_reg         <= lva_pkg::ERR_BITS'(dmin) - lva_pkg::ERR_BITS'(dmaj);
            cnt_reg       <= dmaj;
            voted_reg     <= '0;
        end
        else if (cmd.walk)
        begin
            m_reg   <= m_reg + 1'b1;
            cnt_reg <= cnt_reg - 1'b1;
            if (issue)
            begin
                voted_reg <= voted_reg + 1'b1;
            end
            if (e_nonneg)
            begin
                if (k_move_reg)
                begin
                    k_reg <= k_up_reg ? k_reg + 1'b1 : k_reg - 1'b1;
                end
                e_reg <= e_reg - lva_pkg::ERR_BITS'(dmaj_reg) + lva_pkg::ERR_BITS'(dmin_reg);
            end
            else
            begin
                e_reg <= e_reg + lva_pkg::ERR_BITS'(dmin_reg);
            end
        end
        if (cmd.load_out)
        begin
            if (item_reg.operation == lva_pkg::OP_READ)
            begin
                out_payload_reg.vote_count  <= rd_oob_reg ? '0
                                             : lva_pkg::VOTE_BITS'(rd_data_reg);
                out_payload_reg.cells_voted <= '0;
            end
            else
            begin
                out_payload_reg.vote_count  <= '0;
                out_payload_reg.cells_voted <= voted_reg;
            end
        end
    end

    // Status to controller
    always_comb
    begin
        sts.clear_last = (clr_addr_reg == CLR_LAST);
        sts.op_read    = (item_reg.operation == lva_pkg::OP_READ);
        sts.zero_len   = (dr_abs == '0) && (dc_abs == '0);
        sts.walk_last  = (cnt_reg == '0);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_payload = out_payload_reg;

endmodule

// ===== hw/rtl/line_vote_accumulator_core.sv =====
// Channel | Dir | Payload                                           | Handshake
// req     | in  | operation, start/end row/col, read_row, read_col  | valid/ready
// rsp     | out | vote_count, cells_voted                           | valid/ready
// cfg     | in  | cfg_index (0 height, 1 width), cfg_data           | cfg_we only
//
// Vote: setup, one cell per cycle along the major axis, in image or not, drain, load;
// read and write back overlap. Zero-length vote: setup, load. Read: setup, memory read,
// load. After reset a clearing pass zeroes the store, one cell a cycle; no request is
// taken during it. One request in flight; the load waits while rsp holds an untaken
// result, and rsp holds it while the next request is accepted and worked on.

`include "line_vote_accumulator_core_defines.svh"

module line_vote_accumulator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    lva_req_if.sink                           req,
    lva_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [lva_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lva_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    lva_pkg::cmd_t cmd;
    lva_pkg::sts_t sts;

    lva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lva_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_payload (req.payload),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_payload (rsp.payload),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // One transaction in flight: no second accept right after one
    `LVA_ASSERT_NEXT(a_single_item, req.valid && req.ready, !req.ready, "request accepted twice in a row")

    // A result is only loaded when the output register can take it
    `LVA_ASSERT_NOW(a_load_free, cmd.load_out, sts.out_free, "result overwrote a pending response")

    // A response carries either a read count or a vote tally, never both
    `LVA_ASSERT_NOW(a_rsp_exclusive, rsp.valid, (rsp.payload.vote_count == '0) || (rsp.payload.cells_voted == '0), "response mixes read and vote fields")

endmodule

// ===== dv/tb_line_vote_accumulator_core.sv =====
module tb_line_vote_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lva_pkg::*;

    localparam int HAMMER_VOTES     = 40;
    localparam int RANDOM_PER_PHASE = 134;
    localparam int NUM_SIZES        = 10;
    localparam int WATCHDOG_LIMIT   = 800000;
    localparam int END_CYCLES       = 64;

    // Receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

    // Scoreboard: own copy of the vote store and image size, expected responses in order
    class vote_scoreboard;
        bit [COUNT_BITS-1:0] counts [DEPTH];
        int                  rows_in_use;
        int                  cols_in_use;
        rsp_t                expected_q [$];
        int unsigned         failures;
        int unsigned         vote_items;
        int unsigned         read_items;
        int unsigned         cells_total;

        function new();
            rows_in_use = MAX_ROWS;
            cols_in_use = MAX_COLS;
        endfunction

        function void set_dim(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
            if (idx == CFG_IMAGE_HEIGHT)
                rows_in_use = (val > MAX_ROWS) ? MAX_ROWS : int'(val);
            else if (idx == CFG_IMAGE_WIDTH)
                cols_in_use = (val > MAX_COLS) ? MAX_COLS : int'(val);
        endfunction

        // One saturating vote; returns 1 when the cell lies in the image
        function int unsigned vote_cell(int row, int col);
            int idx;
            if (row < 0 || col < 0 || row >= rows_in_use || col >= cols_in_use)
                return 0;
            idx = row * MAX_COLS + col;
            if (counts[idx] != {COUNT_BITS{1'b1}})
                counts[idx]++;
            return 1;
        endfunction

        // Bresenham walk along the major axis, lower major coordinate first
        function int unsigned rasterize_votes(int r1, int c1, int r2, int c2);
            int          d_row, d_col, lo_maj, hi_maj, minor, far_minor;
            int          d_maj, d_min, dir, err, tmp;
            bit          by_col;
            int unsigned hits;
            d_row = (r1 > r2) ? r1 - r2 : r2 - r1;
            d_col = (c1 > c2) ? c1 - c2 : c2 - c1;
            if (d_row == 0 && d_col == 0)
                return 0;
            by_col = (d_row <= d_col);
            if (by_col)
            begin
                lo_maj = c1; hi_maj = c2; minor = r1; far_minor = r2;
                d_maj = d_col; d_min = d_row;
            end
            else
            begin
                lo_maj = r1; hi_maj = r2; minor = c1; far_minor = c2;
                d_maj = d_row; d_min = d_col;
            end
            if (hi_maj < lo_maj)
            begin
                tmp = lo_maj; lo_maj = hi_maj; hi_maj = tmp;
                tmp = minor; minor = far_minor; far_minor = tmp;
            end
            dir  = (far_minor > minor) ? 1 : ((far_minor < minor) ? -1 : 0);
            err  = d_min - d_maj;
            hits = 0;
            for (int m = lo_maj; m <= hi_maj; m++)
            begin
                hits += by_col ? vote_cell(minor, m) : vote_cell(m, minor);
                if (err >= 0)
                begin
                    minor += dir;
                    err   -= d_maj;
                end
                err += d_min;
            end
            return hits;
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            int unsigned hits;
            e = '0;
            if (r.operation == OP_VOTE)
            begin
                hits = rasterize_votes($signed(r.start_row), $signed(r.start_col),
                                       $signed(r.end_row), $signed(r.end_col));
                e.cells_voted = hits[VOTED_BITS-1:0];
                vote_items++;
                cells_total += hits;
            end
            else
            begin
                e.vote_count = counts[int'(r.read_row) * MAX_COLS + int'(r.read_col)];
                read_items++;
            end
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response with nothing outstanding: vote_count=%0d cells_voted=%0d",
                       got.vote_count, got.cells_voted);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.vote_count !== e.vote_count)
            begin
                $error("vote_count mismatch: expected %0d, actual %0d",
                       e.vote_count, got.vote_count);
                failures++;
            end
            if (got.cells_voted !== e.cells_voted)
            begin
                $error("cells_voted mismatch: expected %0d, actual %0d",
                       e.cells_voted, got.cells_voted);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    lva_req_if req_ch ();
    lva_rsp_if rsp_ch ();

    vote_scoreboard sb;

    bit       pacing_on;
    bit       rx_hold;
    int       burst_left;
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_tick;
    int       idle_cycles;
    int       last_row;
    int       last_col;
    int       phase_rows [NUM_SIZES];
    int       phase_cols [NUM_SIZES];

    line_vote_accumulator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Response checking
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response(rsp_ch.payload);
    end

    // Receiver stalls: a random pattern, redrawn when its run ends
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 400);
        end
        else
            rx_left--;
        rx_tick++;
        if (rx_hold || rx_mode == RX_OPEN)
            rsp_ch.ready <= 1'b1;
        else if (rx_mode == RX_COIN)
            rsp_ch.ready <= 1'($urandom_range(0, 1));
        else if (rx_mode == RX_EVERY4)
            rsp_ch.ready <= (rx_tick % 4 == 0);
        else
            rsp_ch.ready <= ($urandom_range(0, 9) == 0);
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_line_vote_accumulator_core failed");
            $finish;
        end
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int any_sign();
        return $urandom_range(0, 1) ? 1 : -1;
    endfunction

    function automatic req_t vote_req(int r1, int c1, int r2, int c2);
        req_t item;
        item.operation = OP_VOTE;
        item.start_row = coord_t'(r1);
        item.start_col = coord_t'(c1);
        item.end_row   = coord_t'(r2);
        item.end_col   = coord_t'(c2);
        item.read_row  = READ_BITS'($urandom);
        item.read_col  = READ_BITS'($urandom);
        return item;
    endfunction

    function automatic req_t read_req(int row, int col);
        req_t item;
        item.operation = OP_READ;
        item.start_row = coord_t'($urandom);
        item.start_col = coord_t'($urandom);
        item.end_row   = coord_t'($urandom);
        item.end_col   = coord_t'($urandom);
        item.read_row  = READ_BITS'(row);
        item.read_col  = READ_BITS'(col);
        return item;
    endfunction

    // Random mix: reads aimed at voted cells, short and hot-spot votes, lines along
    // axes and diagonals, zero-length, image-edge and full-range segments
    function automatic req_t random_item();
        int kind;
        int span_r;
        int span_c;
        int r1, c1, r2, c2, len, shape;
        kind   = $urandom_range(0, 99);
        span_r = (sb.rows_in_use < 16) ? 16 : sb.rows_in_use;
        span_c = (sb.cols_in_use < 16) ? 16 : sb.cols_in_use;
        if (kind < 35)
        begin
            shape = $urandom_range(0, 3);
            if (shape < 2)
                return read_req(last_row, last_col);
            else if (shape == 2)
                return read_req(pick(0, 31), pick(0, 31));
            else
                return read_req(pick(0, 511), pick(0, 511));
        end
        if (kind < 60)
        begin
            r1 = pick(-8, span_r + 8);
            c1 = pick(-8, span_c + 8);
            r2 = r1 + pick(-40, 40);
            c2 = c1 + pick(-40, 40);
        end
        else if (kind < 75)
        begin
            r1 = pick(0, 31); c1 = pick(0, 31);
            r2 = pick(0, 31); c2 = pick(0, 31);
        end
        else if (kind < 85)
        begin
            len = pick(1, 60);
            r1  = ($urandom_range(0, 3) == 0) ? 0 : pick(-4, span_r + 4);
            c1  = ($urandom_range(0, 3) == 0) ? 0 : pick(-4, span_c + 4);
            shape = $urandom_range(0, 3);
            r2 = r1;
            c2 = c1;
            if (shape == 0)
                c2 = c1 + any_sign() * len;
            else if (shape == 1)
                r2 = r1 + any_sign() * len;
            else if (shape == 2)
            begin
                r2 = r1 + len;
                c2 = c1 + len;
            end
            else
            begin
                r2 = r1 + len;
                c2 = c1 - len;
            end
        end
        else if (kind < 91)
        begin
            r1 = pick(-4, span_r + 4);
            c1 = pick(-4, span_c + 4);
            r2 = r1;
            c2 = c1;
        end
        else if (kind < 97)
        begin
            r1 = sb.rows_in_use - 1 + pick(-3, 3);
            c1 = sb.cols_in_use - 1 + pick(-3, 3);
            r2 = pick(-8, span_r + 8);
            c2 = pick(-8, span_c + 8);
        end
        else
        begin
            r1 = pick(-2048, 2047); c1 = pick(-2048, 2047);
            r2 = pick(-2048, 2047); c2 = pick(-2048, 2047);
        end
        if (r1 >= 0 && r1 < MAX_ROWS && c1 >= 0 && c1 < MAX_COLS)
        begin
            last_row = r1;
            last_col = c1;
        end
        return vote_req(r1, c1, r2, c2);
    endfunction

    // Hold one transaction on the request channel until accepted
    task automatic push_request(input req_t item);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(item);
    endtask

    // Send with bursts and gaps
    task automatic send(input req_t item);
        int gap;
        push_request(item);
        if (!pacing_on)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 24);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_dim(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_dim(idx, CFG_DATA_BITS'(val));
    endtask

    initial
    begin
        sb = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready  = 1'b0;
        pacing_on     = 1'b1;
        rx_hold       = 1'b0;
        burst_left    = 0;
        rx_mode       = RX_OPEN;
        rx_left       = 0;
        rx_tick       = 0;
        idle_cycles   = 0;
        last_row      = 0;
        last_col      = 0;
        phase_rows    = '{1, 0, 300, 1023, 513, 64, 200, 512, 37, 0};
        phase_cols    = '{1, 300, 0, 1023, 600, 48, 512, 200, 511, 0};
        phase_rows[NUM_SIZES-1] = $urandom_range(1, 512);
        phase_cols[NUM_SIZES-1] = $urandom_range(1, 512);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, axis and diagonal lines, full-range and off-image segments
        send(vote_req(10, 10, 10, 10));
        send(vote_req(0, 5, 0, 0));
        send(vote_req(7, 0, 0, 0));
        send(vote_req(0, 0, 7, 7));
        send(vote_req(7, 0, 0, 7));
        send(vote_req(2, 1, 5, 12));
        send(vote_req(20, 3, 3, 9));
        send(vote_req(-2048, -2048, 2047, 2047));
        send(vote_req(2047, -2048, -2048, 2047));
        send(vote_req(-2048, 0, 2047, 0));
        send(vote_req(511, -2048, 511, 2047));
        send(vote_req(-5, 600, -5, 700));
        send(vote_req(510, 510, 513, 514));
        send(read_req(0, 0));
        send(read_req(511, 511));
        send(read_req(0, 5));
        send(read_req(3, 4));
        send(read_req(7, 0));
        send(read_req(511, 0));
        send(read_req(300, 300));

        // Back to back: hammer two cells with repeated votes, then read them
        drain();
        pacing_on = 1'b0;
        rx_hold   = 1'b1;
        for (int n = 0; n < HAMMER_VOTES; n++)
            send(vote_req(400, 20, 400, 21));
        send(read_req(400, 20));
        send(read_req(400, 21));
        send(vote_req(400, 18, 400, 23));
        send(read_req(400, 21));
        drain();
        pacing_on = 1'b1;
        rx_hold   = 1'b0;

        // Random traffic under each image size
        for (int p = 0; p < NUM_SIZES; p++)
        begin
            drain();
            write_dim(CFG_IMAGE_HEIGHT, phase_rows[p]);
            write_dim(CFG_IMAGE_WIDTH, phase_cols[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2 && p % 3 == 0)
                    drain();
                send(random_item());
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);
        $display("Covered %0d vote and %0d read transactions, %0d cells voted,",
                 sb.vote_items, sb.read_items, sb.cells_total);
        $display("%0d image sizes plus reset size, repeated votes on one spot, off-image segments",
                 NUM_SIZES);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_line_vote_accumulator_core passed");
        else
            $display("tb_line_vote_accumulator_core failed");
        $finish;
    end

endmodule
